[rtl/tcb_pkg.sv]
// Shared types and constants of the text console buffer.
package tcb_pkg;

	localparam logic [1:0] OP_CHAR = 2'd0;
	localparam logic [1:0] OP_KEY  = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [15:0] CH_BS    = 16'h0008;
	localparam logic [15:0] CH_TAB   = 16'h0009;
	localparam logic [15:0] CH_LF    = 16'h000A;
	localparam logic [15:0] CH_CR    = 16'h000D;
	localparam logic [15:0] CH_ESC   = 16'h001B;
	localparam logic [15:0] CH_SPACE = 16'h0020;

	localparam logic [15:0] KEY_HOME  = 16'd0;
	localparam logic [15:0] KEY_END   = 16'd1;
	localparam logic [15:0] KEY_PGUP  = 16'd2;
	localparam logic [15:0] KEY_PGDN  = 16'd3;
	localparam logic [15:0] KEY_LEFT  = 16'd4;
	localparam logic [15:0] KEY_RIGHT = 16'd5;
	localparam logic [15:0] KEY_UP    = 16'd6;
	localparam logic [15:0] KEY_DOWN  = 16'd7;
	localparam logic [15:0] KEY_DEL   = 16'd8;

	localparam logic REG_COLUMNS = 1'b0;
	localparam logic REG_ROWS    = 1'b1;

	localparam int COLS_RESET = 80;
	localparam int ROWS_RESET = 25;

	localparam int Q_DEPTH = 2;

	typedef enum logic [4:0] {
		K_NOP,
		K_PUT,
		K_BS,
		K_TAB,
		K_LF,
		K_CR,
		K_ESC,
		K_HOME,
		K_END,
		K_PGUP,
		K_PGDN,
		K_LEFT,
		K_RIGHT,
		K_UP,
		K_DOWN,
		K_DEL,
		K_READ
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] code;
		logic [7:0]  reps;
		logic [6:0]  rcol;
		logic [5:0]  rrow;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} bk_stat_t;

endpackage

[rtl/tcb_front.sv]
// Front end: takes input beats, decodes them into commands and queues them.
module tcb_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       op,
	input  logic [15:0]      code,
	input  logic [7:0]       repeat_count,
	input  logic [6:0]       read_column,
	input  logic [5:0]       read_row,
	input  tcb_pkg::bk_stat_t status,
	output tcb_pkg::head_t   head
);
	import tcb_pkg::*;

	cmd_t       cmd_c;
	cmd_t       fifo_q [Q_DEPTH];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       full;

	always_comb begin
		cmd_c.code = code;
		cmd_c.reps = repeat_count;
		cmd_c.rcol = read_column;
		cmd_c.rrow = read_row;
		cmd_c.kind = K_NOP;
		case (op)
			OP_CHAR: begin
				if (repeat_count != 8'd0) begin
					case (code)
						CH_BS:   cmd_c.kind = K_BS;
						CH_TAB:  cmd_c.kind = K_TAB;
						CH_LF:   cmd_c.kind = K_LF;
						CH_CR:   cmd_c.kind = K_CR;
						CH_ESC:  cmd_c.kind = K_ESC;
						default: cmd_c.kind = K_PUT;
					endcase
				end
			end
			OP_KEY: begin
				case (code)
					KEY_HOME:  cmd_c.kind = K_HOME;
					KEY_END:   cmd_c.kind = K_END;
					KEY_PGUP:  cmd_c.kind = K_PGUP;
					KEY_PGDN:  cmd_c.kind = K_PGDN;
					KEY_LEFT:  cmd_c.kind = K_LEFT;
					KEY_RIGHT: cmd_c.kind = K_RIGHT;
					KEY_UP:    cmd_c.kind = K_UP;
					KEY_DOWN:  cmd_c.kind = K_DOWN;
					KEY_DEL:   cmd_c.kind = K_DEL;
					default:   cmd_c.kind = K_NOP;
				endcase
			end
			OP_READ: cmd_c.kind = K_READ;
			default: cmd_c.kind = K_NOP;
		endcase
	end

	assign full     = (cnt_q == 2'(Q_DEPTH));
	assign in_stall = full | status.clearing;
	assign push     = in_valid & ~in_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= cmd_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (status.pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(status.pop);
		end
	end

	assign head.valid = (cnt_q != 2'd0);
	assign head.cmd   = fifo_q[rd_q];

endmodule

[rtl/tcb_back.sv]
// Back end: runs queued commands against the character grid and the caret.
module tcb_back #(
	parameter int MAX_COLUMNS = 128,
	parameter int MAX_ROWS    = 64,
	parameter int TAB_STOP    = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tcb_pkg::head_t    head,
	output tcb_pkg::bk_stat_t status,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [6:0]        caret_column,
	output logic [5:0]        caret_row,
	output logic [15:0]       cell_value
);
	import tcb_pkg::*;

	localparam int COL_W    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CNT_W    = $clog2(MAX_COLUMNS + 1);
	localparam int RCNT_W   = $clog2(MAX_ROWS + 1);
	localparam int ADDR_W   = ROW_W + COL_W;
	localparam int COL_SPAN = 1 << COL_W;
	localparam int CELLS    = 1 << ADDR_W;
	localparam logic [CNT_W-1:0] COLS_RST =
		CNT_W'((COLS_RESET > MAX_COLUMNS) ? MAX_COLUMNS : COLS_RESET);
	localparam logic [RCNT_W-1:0] ROWS_RST =
		RCNT_W'((ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ROWS_RESET);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_EXEC    = 8'b0000_0010,
		S_DEL_RD  = 8'b0000_0100,
		S_DEL_WR  = 8'b0000_1000,
		S_DEL_END = 8'b0001_0000,
		S_CLEAR   = 8'b0010_0000,
		S_READ    = 8'b0100_0000,
		S_DONE    = 8'b1000_0000
	} state_t;

	state_t              state_q;
	cmd_t                cur_q;
	logic [7:0]          rep_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic [CNT_W-1:0]    cols_q;
	logic [RCNT_W-1:0]   rows_q;
	logic [COL_W-1:0]    x_q;
	logic [ADDR_W-1:0]   clr_q;
	logic                clr_item_q;
	logic [15:0]         cell_q;
	logic                out_valid_q;
	logic [6:0]          caret_col_q;
	logic [5:0]          caret_row_q;
	logic [15:0]         cell_out_q;

	logic [15:0]         mem [CELLS];
	logic [15:0]         rdata_q;
	logic                we_c;
	logic [ADDR_W-1:0]   waddr_c;
	logic [ADDR_W-1:0]   raddr_c;
	logic [15:0]         wdata_c;

	logic [COL_SPAN-1:0] tab_hit_w;
	logic                col_last;
	logic                row_last;
	logic [COL_W-1:0]    col_adv;
	logic [ROW_W-1:0]    row_adv;
	logic [COL_W-1:0]    cols_m1;
	logic [ROW_W-1:0]    rows_m1;
	logic                rd_in_range;
	logic                out_free;
	logic                load_out_c;
	logic [CNT_W-1:0]    cols_new;
	logic [RCNT_W-1:0]   rows_new;

	for (genvar g = 0; g < COL_SPAN; g++) begin : g_tab
		assign tab_hit_w[g] = ((g % TAB_STOP) == 0);
	end

	assign col_last    = (9'(col_q) + 9'd1 >= 9'(cols_q));
	assign row_last    = (8'(row_q) + 8'd1 >= 8'(rows_q));
	assign col_adv     = col_last ? '0 : col_q + COL_W'(1);
	assign row_adv     = row_last ? '0 : row_q + ROW_W'(1);
	assign cols_m1     = COL_W'(cols_q - CNT_W'(1));
	assign rows_m1     = ROW_W'(rows_q - RCNT_W'(1));
	assign rd_in_range = (9'(cur_q.rcol) < 9'(cols_q)) && (8'(cur_q.rrow) < 8'(rows_q));
	assign out_free    = ~out_valid_q | ~out_stall;
	assign load_out_c  = (state_q == S_DONE) & out_free & ~cfg_we;

	always_comb begin
		if (cfg_data == 8'd0) begin
			cols_new = CNT_W'(1);
		end else if (9'(cfg_data) > 9'(MAX_COLUMNS)) begin
			cols_new = CNT_W'(MAX_COLUMNS);
		end else begin
			cols_new = CNT_W'(cfg_data);
		end
		if (cfg_data[6:0] == 7'd0) begin
			rows_new = RCNT_W'(1);
		end else if (8'(cfg_data[6:0]) > 8'(MAX_ROWS)) begin
			rows_new = RCNT_W'(MAX_ROWS);
		end else begin
			rows_new = RCNT_W'(cfg_data[6:0]);
		end
	end

	always_comb begin
		we_c    = 1'b0;
		waddr_c = {row_q, col_q};
		wdata_c = CH_SPACE;
		raddr_c = {row_q, x_q + COL_W'(1)};
		case (state_q)
			S_EXEC: begin
				raddr_c = {ROW_W'(cur_q.rrow), COL_W'(cur_q.rcol)};
				if (rep_q != 8'd0 && cur_q.kind == K_PUT) begin
					we_c    = 1'b1;
					wdata_c = cur_q.code;
				end
				if (rep_q != 8'd0 && cur_q.kind == K_TAB) begin
					we_c = 1'b1;
				end
			end
			S_DEL_WR: begin
				we_c    = 1'b1;
				waddr_c = {row_q, x_q};
				wdata_c = rdata_q;
			end
			S_DEL_END: begin
				we_c    = 1'b1;
				waddr_c = {row_q, cols_m1};
			end
			S_CLEAR: begin
				we_c    = 1'b1;
				waddr_c = clr_q;
			end
			default: begin
				we_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_c) begin
			mem[waddr_c] <= wdata_c;
		end
		rdata_q <= mem[raddr_c];
	end

	assign status.pop      = (state_q == S_IDLE) & head.valid & ~cfg_we;
	assign status.clearing = (state_q == S_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			clr_item_q  <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			cols_q      <= COLS_RST;
			rows_q      <= ROWS_RST;
			rep_q       <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out_c) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				if (cfg_index == REG_COLUMNS) begin
					cols_q <= cols_new;
				end else begin
					rows_q <= rows_new;
				end
				col_q      <= '0;
				row_q      <= '0;
				clr_q      <= '0;
				clr_item_q <= 1'b0;
				state_q    <= S_CLEAR;
			end else begin
				case (state_q)
					S_IDLE: begin
						if (head.valid) begin
							cur_q   <= head.cmd;
							rep_q   <= head.cmd.reps;
							cell_q  <= 16'd0;
							state_q <= S_EXEC;
						end
					end
					S_EXEC: begin
						case (cur_q.kind)
							K_PUT, K_TAB, K_LF, K_CR: begin
								if (rep_q == 8'd0) begin
									state_q <= S_DONE;
								end else if (cur_q.kind == K_LF) begin
									row_q <= row_adv;
									rep_q <= rep_q - 8'd1;
								end else if (cur_q.kind == K_CR) begin
									col_q <= '0;
									row_q <= row_adv;
									rep_q <= rep_q - 8'd1;
								end else begin
									col_q <= col_adv;
									if (col_last) begin
										row_q <= row_adv;
									end
									if (cur_q.kind == K_PUT || tab_hit_w[col_adv]) begin
										rep_q <= rep_q - 8'd1;
									end
								end
							end
							K_BS: begin
								if (rep_q == 8'd0) begin
									state_q <= S_DONE;
								end else begin
									rep_q <= rep_q - 8'd1;
									if (col_q != '0) begin
										col_q   <= col_q - COL_W'(1);
										x_q     <= col_q - COL_W'(1);
										state_q <= S_DEL_RD;
									end
								end
							end
							K_ESC: begin
								if (rep_q == 8'd0) begin
									state_q <= S_DONE;
								end else begin
									col_q      <= '0;
									row_q      <= '0;
									clr_q      <= '0;
									clr_item_q <= 1'b1;
									state_q    <= S_CLEAR;
								end
							end
							K_HOME: begin
								col_q   <= '0;
								state_q <= S_DONE;
							end
							K_END: begin
								col_q   <= cols_m1;
								state_q <= S_DONE;
							end
							K_PGUP: begin
								row_q   <= '0;
								state_q <= S_DONE;
							end
							K_PGDN: begin
								row_q   <= rows_m1;
								state_q <= S_DONE;
							end
							K_LEFT: begin
								if (col_q != '0) begin
									col_q <= col_q - COL_W'(1);
								end
								state_q <= S_DONE;
							end
							K_RIGHT: begin
								if (!col_last) begin
									col_q <= col_q + COL_W'(1);
								end
								state_q <= S_DONE;
							end
							K_UP: begin
								if (row_q != '0) begin
									row_q <= row_q - ROW_W'(1);
								end
								state_q <= S_DONE;
							end
							K_DOWN: begin
								if (!row_last) begin
									row_q <= row_q + ROW_W'(1);
								end
								state_q <= S_DONE;
							end
							K_DEL: begin
								x_q     <= col_q;
								state_q <= S_DEL_RD;
							end
							K_READ: begin
								state_q <= rd_in_range ? S_READ : S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
					S_DEL_RD: begin
						if (9'(x_q) + 9'd1 < 9'(cols_q)) begin
							state_q <= S_DEL_WR;
						end else begin
							state_q <= S_DEL_END;
						end
					end
					S_DEL_WR: begin
						x_q     <= x_q + COL_W'(1);
						state_q <= S_DEL_RD;
					end
					S_DEL_END: begin
						state_q <= (cur_q.kind == K_DEL) ? S_DONE : S_EXEC;
					end
					S_CLEAR: begin
						clr_q <= clr_q + ADDR_W'(1);
						if (&clr_q) begin
							state_q <= clr_item_q ? S_DONE : S_IDLE;
						end
					end
					S_READ: begin
						cell_q  <= rdata_q;
						state_q <= S_DONE;
					end
					S_DONE: begin
						if (out_free) begin
							caret_col_q <= 7'(col_q);
							caret_row_q <= 6'(row_q);
							cell_out_q  <= cell_q;
							state_q     <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign caret_column = caret_col_q;
	assign caret_row    = caret_row_q;
	assign cell_value   = cell_out_q;

endmodule

[rtl/text_console_buffer.sv]
// Top level of the text console buffer: front end, command queue and back end.
//
// The input channel carries one beat per item (op, code, repeat_count,
// read_column, read_row); the output channel returns one beat per item
// with the caret after the item and, for a read, the cell read, but an item
// cut short by a size register write returns none. Both channels use valid
// and stall. The front end decodes an item and puts it in a two-entry queue;
// the back end runs one command at a time against a single-write, single-read
// grid memory. Every item is taken from the queue in the idle state and hands
// over its result from the done state. A printable character writes one cell
// per repeat, a tab writes spaces up to the next tab stop per repeat, and a
// delete or backspace shifts the rest of the row left one column, reading
// and then writing each cell up to the end of the row.
// Escape, a write of either size register and reset each start a clearing pass
// that writes space to every grid cell, one cell per cycle: 8192 cells with
// the default parameters. Input stalls during the pass.
// When the receiver stalls, the result waits in the output register, the back
// end finishes the next item and holds it, and up to two more items are queued,
// after which input stalls too.
module text_console_buffer #(
	parameter int MAX_COLUMNS = 128,
	parameter int MAX_ROWS    = 64,
	parameter int TAB_STOP    = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [15:0] code,
	input  logic [7:0]  repeat_count,
	input  logic [6:0]  read_column,
	input  logic [5:0]  read_row,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  caret_column,
	output logic [5:0]  caret_row,
	output logic [15:0] cell_value
);
	import tcb_pkg::*;

	head_t    head;
	bk_stat_t status;

	tcb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.code         (code),
		.repeat_count (repeat_count),
		.read_column  (read_column),
		.read_row     (read_row),
		.status       (status),
		.head         (head)
	);

	tcb_back #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS),
		.TAB_STOP    (TAB_STOP)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.caret_column (caret_column),
		.caret_row    (caret_row),
		.cell_value   (cell_value)
	);

endmodule

[rtl/tcb_checker.sv]
// Port checker for the text console buffer and its bind to the top level.
module tcb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        cfg_we,
	input logic        out_valid,
	input logic        out_stall,
	input logic [6:0]  caret_column,
	input logic [5:0]  caret_row,
	input logic [15:0] cell_value
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(caret_column) && $stable(caret_row)
			&& $stable(cell_value))
		else $error("stalled result changed");

	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> in_stall)
		else $error("input not stalled after a size write");

	a_cfg_clear_len: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we ##1 !cfg_we |=> in_stall)
		else $error("clearing pass ended too early");

endmodule

bind text_console_buffer tcb_checker u_tcb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.cfg_we       (cfg_we),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.caret_column (caret_column),
	.caret_row    (caret_row),
	.cell_value   (cell_value)
);
